FILE: hdl/fsca_pkg.sv
package fsca_pkg;

    localparam int GRID_SIZE_DEF = 64;

    typedef logic [1:0] cell_t;

    localparam cell_t CELL_INTACT  = 2'd0;
    localparam cell_t CELL_BURNING = 2'd1;
    localparam cell_t CELL_BURNED  = 2'd2;

    typedef logic [1:0] action_t;

    localparam action_t ACT_WRITE = 2'd0;
    localparam action_t ACT_STEP  = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    // Codes above burned are stored as burned
    function automatic cell_t clamp_cell(input cell_t v);
        cell_t r;
        r = (v > CELL_BURNED) ? CELL_BURNED : v;
        return r;
    endfunction

    function automatic cell_t next_cell(input cell_t v, input logic fire_near);
        cell_t r;
        if (v == CELL_INTACT && fire_near)
        begin
            r = CELL_BURNING;
        end
        else if (v == CELL_BURNING)
        begin
            r = CELL_BURNED;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hdl/fsca_ram.sv
module fsca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/fsca_row_rule.sv
module fsca_row_rule import fsca_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic [2*GRID_SIZE-1:0] above,
    input  logic [2*GRID_SIZE-1:0] centre,
    input  logic [2*GRID_SIZE-1:0] below,
    output logic [2*GRID_SIZE-1:0] next_row
);

    for (genvar c = 0; c < GRID_SIZE; c++)
    begin : g_col
        localparam int L = (c + GRID_SIZE - 1) % GRID_SIZE;
        localparam int R = (c + 1) % GRID_SIZE;

        logic fire_near;

        assign fire_near = (above[2*L +: 2]  == CELL_BURNING)
                        || (above[2*c +: 2]  == CELL_BURNING)
                        || (above[2*R +: 2]  == CELL_BURNING)
                        || (centre[2*L +: 2] == CELL_BURNING)
                        || (centre[2*R +: 2] == CELL_BURNING)
                        || (below[2*L +: 2]  == CELL_BURNING)
                        || (below[2*c +: 2]  == CELL_BURNING)
                        || (below[2*R +: 2]  == CELL_BURNING);

        assign next_row[2*c +: 2] = next_cell(centre[2*c +: 2], fire_near);
    end

endmodule

FILE: hdl/fire_spread_cellular_automaton.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | action, row, column, cell_value
// out     | output    | out_valid/out_ready | read_value, done_res
//
// Each bank holds one grid row per word, so a cell read is a row read and
// a cell write is a row read followed by a write-back. A cell read or
// write passes S_CELL and S_DONE before in_ready returns; S_DONE holds
// while the previous result still waits. A generation streams GRID_SIZE+2
// row reads through a two-row window and the row rule, over the single
// read port of a bank.
// After reset a clearing pass writes every row of both banks to intact with
// in_ready low. One item is in work at a time; a finished result waits in
// the output register while the next item enters.
module fire_spread_cellular_automaton import fsca_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [5:0] row,
    input  logic [5:0] column,
    input  logic [1:0] cell_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] read_value,
    output logic       done_res
);

    localparam int RW   = $clog2(GRID_SIZE);
    localparam int CW   = $clog2(GRID_SIZE + 3);
    localparam int ROWB = 2 * GRID_SIZE;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CELL  = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              bank_reg, bank_next;
    logic              out_valid_reg, out_valid_next;
    logic              rsp_vld_reg, rsp_vld_next;
    logic [CW-1:0]     rsp_cnt_reg, rsp_cnt_next;

    action_t           act_reg, act_next;
    logic [RW-1:0]     rowidx_reg, rowidx_next;
    logic [RW-1:0]     colidx_reg, colidx_next;
    cell_t             val_reg, val_next;
    cell_t             rd_val_reg, rd_val_next;
    cell_t             out_value_reg, out_value_next;
    logic [ROWB-1:0]   prev_reg, prev_next;
    logic [ROWB-1:0]   cur_reg, cur_next;

    logic [RW-1:0]     raddr;
    logic [RW-1:0]     waddr;
    logic [ROWB-1:0]   wdata;
    logic              we0;
    logic              we1;
    logic [ROWB-1:0]   rdata0;
    logic [ROWB-1:0]   rdata1;
    logic [ROWB-1:0]   src_rdata;
    logic [ROWB-1:0]   mod_row;
    logic [ROWB-1:0]   rule_row;
    logic [RW-1:0]     step_addr;
    logic              in_grid;

    fsca_ram #(
        .WIDTH (ROWB),
        .DEPTH (GRID_SIZE)
    ) u_bank_zero (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    fsca_ram #(
        .WIDTH (ROWB),
        .DEPTH (GRID_SIZE)
    ) u_bank_one (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    fsca_row_rule #(
        .GRID_SIZE (GRID_SIZE)
    ) u_rule (
        .above    (prev_reg),
        .centre   (cur_reg),
        .below    (src_rdata),
        .next_row (rule_row)
    );

    assign src_rdata  = bank_reg ? rdata1 : rdata0;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign done_res   = 1'b1;

    assign in_grid = (int'(row) < GRID_SIZE) && (int'(column) < GRID_SIZE);

    // Row order of a generation: last row, then every row, then row zero again
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            step_addr = RW'(GRID_SIZE - 1);
        end
        else if (cnt_reg == CW'(GRID_SIZE + 1))
        begin
            step_addr = '0;
        end
        else
        begin
            step_addr = RW'(cnt_reg - CW'(1));
        end
    end

    always_comb
    begin
        mod_row = src_rdata;
        mod_row[{colidx_reg, 1'b0} +: 2] = clamp_cell(val_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        out_valid_next = out_valid_reg;
        rsp_vld_next   = 1'b0;
        rsp_cnt_next   = cnt_reg;
        act_next       = act_reg;
        rowidx_next    = rowidx_reg;
        colidx_next    = colidx_reg;
        val_next       = val_reg;
        rd_val_next    = rd_val_reg;
        out_value_next = out_value_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        raddr          = '0;
        waddr          = '0;
        wdata          = '0;
        we0            = 1'b0;
        we1            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                waddr = RW'(cnt_reg);
                we0   = 1'b1;
                we1   = 1'b1;
                if (cnt_reg == CW'(GRID_SIZE - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                raddr = RW'(row);
                if (in_valid)
                begin
                    act_next    = action;
                    rowidx_next = RW'(row);
                    colidx_next = RW'(column);
                    val_next    = cell_value;
                    rd_val_next = CELL_INTACT;
                    if (action == ACT_STEP)
                    begin
                        cnt_next   = '0;
                        state_next = S_STEP;
                    end
                    else if (in_grid && (action == ACT_WRITE || action == ACT_READ))
                    begin
                        state_next = S_CELL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CELL:
            begin
                if (act_reg == ACT_WRITE)
                begin
                    waddr = rowidx_reg;
                    wdata = mod_row;
                    we0   = !bank_reg;
                    we1   = bank_reg;
                end
                else
                begin
                    rd_val_next = src_rdata[{colidx_reg, 1'b0} +: 2];
                end
                state_next = S_DONE;
            end

            S_STEP:
            begin
                if (cnt_reg <= CW'(GRID_SIZE + 1))
                begin
                    raddr        = step_addr;
                    rsp_vld_next = 1'b1;
                    cnt_next     = cnt_reg + CW'(1);
                end
                if (rsp_vld_reg)
                begin
                    prev_next = cur_reg;
                    cur_next  = src_rdata;
                    // Window full: write the middle row into the spare bank
                    if (rsp_cnt_reg >= CW'(2))
                    begin
                        waddr = RW'(rsp_cnt_reg - CW'(2));
                        wdata = rule_row;
                        we0   = bank_reg;
                        we1   = !bank_reg;
                    end
                    if (rsp_cnt_reg == CW'(GRID_SIZE + 1))
                    begin
                        bank_next  = !bank_reg;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_val_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rsp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
            rsp_vld_reg   <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_cnt_reg   <= rsp_cnt_next;
        act_reg       <= act_next;
        rowidx_reg    <= rowidx_next;
        colidx_reg    <= colidx_next;
        val_reg       <= val_next;
        rd_val_reg    <= rd_val_next;
        out_value_reg <= out_value_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb import fsca_pkg::*;;

    localparam int GRID           = GRID_SIZE_DEF;
    localparam int CELLS          = GRID * GRID;
    localparam int RANDOM_CMDS    = 118;
    localparam int PHASE_BEATS    = 24;
    localparam int SETTLE_CYCLES  = GRID + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 40;

    // Codes the block must tolerate but does not define
    localparam action_t ACT_UNDEF  = 2'd3;
    localparam cell_t   CELL_UNDEF = 2'd3;

    typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

    typedef struct {
        action_t    act;
        logic [5:0] r;
        logic [5:0] c;
        cell_t      val;
    } fire_cmd_t;

    typedef struct {
        cell_t rd;
        logic  done;
    } cell_reply_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] action     = ACT_READ;
    logic [5:0] row        = '0;
    logic [5:0] column     = '0;
    logic [1:0] cell_value = CELL_INTACT;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [1:0] read_value;
    logic       done_res;

    fire_cmd_t   pending_cmds[$];
    cell_reply_t expected_replies[$];
    fire_cmd_t   cur_cmd;
    int          beats_in       = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;

    // Shadow copy of both grid banks
    cell_t grid_cells[2][CELLS];
    bit    live_bank;

    fire_spread_cellular_automaton dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .row       (row),
        .column    (column),
        .cell_value(cell_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_value(read_value),
        .done_res  (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic idle_phase_t cur_phase();
        return idle_phase_t'((beats_in / PHASE_BEATS) % 4);
    endfunction

    function automatic int send_idle_pct(idle_phase_t ph);
        return (ph == PH_SEND) ? 52 : (ph == PH_BOTH) ? 35 : 0;
    endfunction

    function automatic int recv_stall_pct(idle_phase_t ph);
        return (ph == PH_RECV) ? 52 : (ph == PH_BOTH) ? 35 : 0;
    endfunction

    function automatic int wrap(int x);
        return ((x % GRID) + GRID) % GRID;
    endfunction

    function automatic bit fire_near(int r, int c);
        int  dr;
        int  dc;
        bit  hit;
        hit = 1'b0;
        for (dr = -1; dr <= 1; dr++)
        begin
            for (dc = -1; dc <= 1; dc++)
            begin
                if ((dr != 0 || dc != 0) &&
                    grid_cells[live_bank][wrap(r + dr) * GRID + wrap(c + dc)] == CELL_BURNING)
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // Build the next generation in the spare bank, then swap
    function automatic void advance_generation();
        int    r;
        int    c;
        int    k;
        cell_t v;
        for (r = 0; r < GRID; r++)
        begin
            for (c = 0; c < GRID; c++)
            begin
                k = r * GRID + c;
                v = grid_cells[live_bank][k];
                if (v == CELL_INTACT && fire_near(r, c))
                begin
                    grid_cells[~live_bank][k] = CELL_BURNING;
                end
                else if (v == CELL_BURNING)
                begin
                    grid_cells[~live_bank][k] = CELL_BURNED;
                end
                else
                begin
                    grid_cells[~live_bank][k] = v;
                end
            end
        end
        live_bank = ~live_bank;
    endfunction

    function automatic cell_reply_t predict_reply(fire_cmd_t cmd);
        cell_reply_t rep;
        bit          on_grid;
        int          k;
        rep.rd   = CELL_INTACT;
        rep.done = 1'b1;
        on_grid  = (int'(cmd.r) < GRID) && (int'(cmd.c) < GRID);
        k        = int'(cmd.r) * GRID + int'(cmd.c);
        case (cmd.act)
            ACT_WRITE:
            begin
                if (on_grid)
                begin
                    grid_cells[live_bank][k] = (cmd.val > CELL_BURNED) ? CELL_BURNED : cmd.val;
                end
            end
            ACT_STEP:
            begin
                advance_generation();
            end
            ACT_READ:
            begin
                if (on_grid)
                begin
                    rep.rd = grid_cells[live_bank][k];
                end
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic add_cmd(input action_t act, input int r, input int c, input cell_t val);
        fire_cmd_t cmd;
        cmd.act = act;
        cmd.r   = r[5:0];
        cmd.c   = c[5:0];
        cmd.val = val;
        pending_cmds.push_back(cmd);
    endtask

    // Driver: when the port is free, present the next command unless a random idle gap is drawn
    always @(posedge clk)
    begin : drive_blk
        bit take;
        if (rst_n)
        begin
            take = !in_valid;
            if (in_valid && in_ready)
            begin
                expected_replies.push_back(predict_reply(cur_cmd));
                beats_in++;
                take = 1'b1;
            end
            if (take)
            begin
                if (pending_cmds.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct(cur_phase()))
                begin
                    cur_cmd    = pending_cmds.pop_front();
                    in_valid   <= 1'b1;
                    action     <= cur_cmd.act;
                    row        <= cur_cmd.r;
                    column     <= cur_cmd.c;
                    cell_value <= cur_cmd.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin : watch_blk
        cell_reply_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected beat read_value=%0d done_res=%0d",
                                            read_value, done_res));
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (read_value !== want.rd)
                    begin
                        flag_mismatch($sformatf("read_value got %0d want %0d",
                                                read_value, want.rd));
                    end
                    if (done_res !== want.done)
                    begin
                        flag_mismatch($sformatf("done_res got %0d want %0d",
                                                done_res, want.done));
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase()));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stim_blk
        int i;
        int r0;
        int c0;
        int n;
        int steps;
        int reach;
        int total;

        for (i = 0; i < CELLS; i++)
        begin
            grid_cells[0][i] = CELL_INTACT;
            grid_cells[1][i] = CELL_INTACT;
        end
        live_bank = 1'b0;

        // Corners, wrap-around spread, clamped and undefined codes
        add_cmd(ACT_READ,  0,  0,  CELL_INTACT);
        add_cmd(ACT_WRITE, 0,  0,  CELL_BURNING);
        add_cmd(ACT_WRITE, 63, 63, CELL_UNDEF);
        add_cmd(ACT_WRITE, 0,  63, CELL_BURNED);
        add_cmd(ACT_WRITE, 63, 0,  CELL_INTACT);
        add_cmd(ACT_READ,  63, 63, CELL_UNDEF);
        add_cmd(ACT_READ,  0,  0,  CELL_BURNED);
        add_cmd(ACT_UNDEF, 63, 63, CELL_UNDEF);
        add_cmd(ACT_READ,  63, 63, CELL_INTACT);
        add_cmd(ACT_STEP,  63, 63, CELL_UNDEF);
        add_cmd(ACT_READ,  63, 0,  CELL_INTACT);
        add_cmd(ACT_READ,  1,  63, CELL_INTACT);
        add_cmd(ACT_READ,  63, 1,  CELL_INTACT);
        add_cmd(ACT_READ,  0,  0,  CELL_INTACT);
        add_cmd(ACT_STEP,  0,  0,  CELL_INTACT);
        add_cmd(ACT_READ,  62, 63, CELL_INTACT);
        add_cmd(ACT_READ,  2,  2,  CELL_INTACT);
        add_cmd(ACT_READ,  63, 63, CELL_INTACT);
        add_cmd(ACT_STEP,  21, 42, CELL_BURNING);
        add_cmd(ACT_READ,  3,  3,  CELL_INTACT);
        add_cmd(ACT_WRITE, 42, 21, CELL_BURNING);
        add_cmd(ACT_READ,  42, 21, CELL_BURNED);

        // Mostly ignite-step-probe sequences, some loose noise
        total = pending_cmds.size() + RANDOM_CMDS;
        while (pending_cmds.size() < total)
        begin
            if ($urandom_range(99) < 75)
            begin
                r0 = $urandom_range(GRID - 1);
                c0 = $urandom_range(GRID - 1);
                add_cmd(ACT_WRITE, r0, c0, CELL_BURNING);
                n = $urandom_range(3);
                repeat (n)
                begin
                    add_cmd(ACT_WRITE, wrap(r0 + int'($urandom_range(4)) - 2),
                            wrap(c0 + int'($urandom_range(4)) - 2), cell_t'($urandom_range(3)));
                end
                steps = $urandom_range(1, 3);
                repeat (steps)
                begin
                    add_cmd(ACT_STEP, $urandom_range(63), $urandom_range(63),
                            cell_t'($urandom_range(3)));
                end
                reach = steps + 1;
                n = $urandom_range(2, 5);
                repeat (n)
                begin
                    add_cmd(ACT_READ, wrap(r0 + int'($urandom_range(2 * reach)) - reach),
                            wrap(c0 + int'($urandom_range(2 * reach)) - reach),
                            cell_t'($urandom_range(3)));
                end
            end
            else
            begin
                add_cmd(action_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                        cell_t'($urandom_range(3)));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || in_valid || expected_replies.size() > 0)
        begin
            @(posedge clk);
        end
        // Hold a little longer to catch stray beats
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_replies.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
